// ===== rtl/lss_pkg.sv =====
`timescale 1ns / 1ps
// lss_pkg: shared types and constants of the statistics stack
package lss_pkg;

  // fixed field widths
  localparam int DATA_W  = 32;
  localparam int MEAN_W  = 40;
  localparam int COUNT_W = 8;
  localparam int FRAC_W  = 8;

  // request modes
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_STATS = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DIV_START,
    S_DIV_WAIT,
    S_FINISH
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic dispatch;
    logic scan;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  empty;
    logic  scan_last;
    logic  div_done;
    logic  out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/lifo_stack_with_statistics.sv =====
`timescale 1ns / 1ps
// lifo_stack_with_statistics: top level of the bounded stack with statistics
//
// Requests arrive on in_valid_i / in_stall_o with mode_i and value_i; a request
// is taken on a rising edge with in_valid_i high and in_stall_o low. Every
// request gives one result on out_valid_o / out_stall_i: data, status,
// largest, smallest, mean_q8 (Q.8, truncated toward zero) and count.
// Push, pop and peek go from acceptance through capture, one memory access on
// the single-port stack RAM, then the result register. For statistics, the scan
// reads one stored word per cycle from the RAM, then a restoring divider
// produces one quotient bit per cycle, NW = 40 + clog2(DEPTH + 1) bits in all.
// One request is worked on at a time; the next is accepted once the current
// result sits in the output register, so a stalled result does not stop the
// following request from being taken and processed up to its own result.
// A result held under out_stall_i stays unchanged until taken.
// Reset empties the stack and drops any pending result; the RAM is not
// cleared, since only entries below the fill count are ever read.
module lifo_stack_with_statistics #(
  parameter int DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] data_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] largest_o,
  output logic signed [31:0] smallest_o,
  output logic signed [39:0] mean_q8_o,
  output logic [7:0]         count_o
);

  lss_pkg::ctrl_cmd_t cmd;
  lss_pkg::dp_stat_t  stat;

  // request sequencer
  lss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  lss_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .largest_o   (largest_o),
    .smallest_o  (smallest_o),
    .mean_q8_o   (mean_q8_o),
    .count_o     (count_o)
  );

endmodule

// ===== rtl/lss_div.sv =====
`timescale 1ns / 1ps
// lss_div: restoring unsigned divider, one quotient bit per cycle
module lss_div #(
  parameter int NW = 48,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [NW-1:0] quotient_o,
  output logic          done_o
);

  localparam int SCW = (NW > 1) ? $clog2(NW) : 1;

  logic          busy_q, busy_d;
  logic [SCW-1:0] step_q, step_d;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] div_q;
  logic [DW:0]   rem_ext;
  logic          ge;
  logic          last;

  // trial subtraction of one step
  assign rem_ext = {rem_q, quo_q[NW-1]};
  assign ge      = rem_ext >= {1'b0, div_q};
  assign last    = step_q == SCW'(NW - 1);
  assign done_o  = busy_q && last;
  assign quotient_o = quo_q;

  // step control
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + SCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // shift register and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? DW'(rem_ext - {1'b0, div_q}) : DW'(rem_ext);
    end
  end

  // completion is a single-cycle pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("divider done held longer than one cycle");

endmodule

// ===== rtl/lss_dp.sv =====
`timescale 1ns / 1ps
// lss_dp: stack memory, fill count, scan accumulators, divider and result register
module lss_dp #(
  parameter int DEPTH = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lss_pkg::ctrl_cmd_t      cmd_i,
  output lss_pkg::dp_stat_t       stat_o,
  input  logic [1:0]              mode_i,
  input  logic signed [31:0]      value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [31:0]      data_o,
  output logic [1:0]              status_o,
  output logic signed [31:0]      largest_o,
  output logic signed [31:0]      smallest_o,
  output logic signed [39:0]      mean_q8_o,
  output logic [7:0]              count_o
);

  localparam int DATA_W  = lss_pkg::DATA_W;
  localparam int MEAN_W  = lss_pkg::MEAN_W;
  localparam int COUNT_W = lss_pkg::COUNT_W;
  localparam int FRAC_W  = lss_pkg::FRAC_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = DATA_W + CW;
  localparam int NW = SW + FRAC_W;

  // request registers
  lss_pkg::mode_e           mode_q;
  logic signed [DATA_W-1:0] value_q;

  // control state
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          first_q, first_d;
  lss_pkg::status_e st_q, st_d;
  logic          out_valid_q, out_valid_d;

  // memory and scan payload
  logic [DATA_W-1:0]        stack_mem_q [DEPTH];
  logic signed [DATA_W-1:0] rd_q;
  logic signed [SW-1:0]     sum_q;
  logic signed [DATA_W-1:0] hi_q, lo_q;
  logic                     neg_q;

  logic          we, re;
  logic [AW-1:0] wa, ra, top_addr;
  logic          empty, full, scan_last;

  // divider hookup
  logic          sum_neg;
  logic [SW-1:0] sum_mag;
  logic [NW-1:0] dividend;
  logic [NW-1:0] quotient;
  logic          div_done;

  // result registers
  logic signed [DATA_W-1:0] data_q, largest_q, smallest_q;
  logic signed [MEAN_W-1:0] mean_q;
  logic [MEAN_W-1:0]        mean_mag;
  lss_pkg::status_e         status_q;
  logic [COUNT_W-1:0]       count_q;
  logic                     stats_ok, data_ok;

  assign empty     = cnt_q == '0;
  assign full      = cnt_q == CW'(DEPTH);
  assign scan_last = idx_q == cnt_q;
  assign top_addr  = cnt_q[AW-1:0] - AW'(1);

  assign stat_o.mode      = mode_q;
  assign stat_o.empty     = empty;
  assign stat_o.scan_last = scan_last;
  assign stat_o.div_done  = div_done;
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

  // capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= lss_pkg::mode_e'(mode_i);
      value_q <= value_i;
    end
  end

  // mode decode, memory port control and count update
  always_comb begin
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    first_d = first_q;
    st_d    = st_q;
    we      = 1'b0;
    re      = 1'b0;
    wa      = cnt_q[AW-1:0];
    ra      = idx_q[AW-1:0];
    if (cmd_i.dispatch) begin
      case (mode_q)
        lss_pkg::MODE_PUSH: begin
          if (full) begin
            st_d = lss_pkg::ST_FULL;
          end else begin
            st_d  = lss_pkg::ST_OK;
            we    = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end
        end
        lss_pkg::MODE_POP: begin
          if (empty) begin
            st_d = lss_pkg::ST_EMPTY;
          end else begin
            st_d  = lss_pkg::ST_OK;
            re    = 1'b1;
            ra    = top_addr;
            cnt_d = cnt_q - CW'(1);
          end
        end
        lss_pkg::MODE_PEEK: begin
          if (empty) begin
            st_d = lss_pkg::ST_EMPTY;
          end else begin
            st_d = lss_pkg::ST_OK;
            re   = 1'b1;
            ra   = top_addr;
          end
        end
        lss_pkg::MODE_STATS: begin
          if (empty) begin
            st_d = lss_pkg::ST_EMPTY;
          end else begin
            st_d    = lss_pkg::ST_OK;
            re      = 1'b1;
            ra      = '0;
            idx_d   = CW'(1);
            first_d = 1'b1;
          end
        end
        default: begin
          st_d = lss_pkg::ST_OK;
        end
      endcase
    end
    // scan issues the next read while the previous word is folded in
    if (cmd_i.scan) begin
      first_d = 1'b0;
      if (!scan_last) begin
        re    = 1'b1;
        ra    = idx_q[AW-1:0];
        idx_d = idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      st_q        <= lss_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      first_q     <= first_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem_q[wa] <= value_q;
    end
    if (re) begin
      rd_q <= stack_mem_q[ra];
    end
  end

  // running sum, maximum and minimum
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (first_q) begin
        sum_q <= SW'(rd_q);
        hi_q  <= rd_q;
        lo_q  <= rd_q;
      end else begin
        sum_q <= sum_q + SW'(rd_q);
        hi_q  <= (rd_q > hi_q) ? rd_q : hi_q;
        lo_q  <= (rd_q < lo_q) ? rd_q : lo_q;
      end
    end
  end

  // divide the magnitude of sum * 256 by the count, sign restored afterwards
  assign sum_neg  = sum_q[SW-1];
  assign sum_mag  = sum_neg ? SW'(-sum_q) : SW'(sum_q);
  assign dividend = {sum_mag, FRAC_W'(0)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= sum_neg;
    end
  end

  lss_div #(
    .NW(NW),
    .DW(CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // result register
  assign stats_ok = (mode_q == lss_pkg::MODE_STATS) && (st_q == lss_pkg::ST_OK);
  assign data_ok  = ((mode_q == lss_pkg::MODE_POP) || (mode_q == lss_pkg::MODE_PEEK))
                    && (st_q == lss_pkg::ST_OK);
  assign mean_mag = quotient[MEAN_W-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      data_q     <= data_ok ? rd_q : '0;
      status_q   <= st_q;
      largest_q  <= stats_ok ? hi_q : '0;
      smallest_q <= stats_ok ? lo_q : '0;
      mean_q     <= stats_ok ? (neg_q ? -$signed(mean_mag) : $signed(mean_mag)) : '0;
      count_q    <= COUNT_W'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign largest_o   = largest_q;
  assign smallest_o  = smallest_q;
  assign mean_q8_o   = mean_q;
  assign count_o     = count_q;

  // fill count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("fill count beyond capacity");

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  // the scan leaves the stack untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.scan |=> $stable(cnt_q))
    else $error("fill count changed during scan");

endmodule

// ===== rtl/lss_ctrl.sv =====
`timescale 1ns / 1ps
// lss_ctrl: request sequencing state machine
module lss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lss_pkg::dp_stat_t  stat_i,
  output lss_pkg::ctrl_cmd_t cmd_o
);

  lss_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lss_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      lss_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lss_pkg::S_DISPATCH;
        end
      end
      lss_pkg::S_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        if ((stat_i.mode == lss_pkg::MODE_STATS) && !stat_i.empty) begin
          state_d = lss_pkg::S_SCAN;
        end else begin
          state_d = lss_pkg::S_FINISH;
        end
      end
      lss_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = lss_pkg::S_DIV_START;
        end
      end
      lss_pkg::S_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = lss_pkg::S_DIV_WAIT;
      end
      lss_pkg::S_DIV_WAIT: begin
        if (stat_i.div_done) begin
          state_d = lss_pkg::S_FINISH;
        end
      end
      lss_pkg::S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = lss_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/lss_result_checker.sv =====
`timescale 1ns / 1ps
// lss_result_checker: predicts and checks every result of the statistics stack
module lss_result_checker #(
  parameter int DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_stall_i,
  input  logic [1:0]         req_mode_i,
  input  logic signed [31:0] req_value_i,
  input  logic               rsp_valid_i,
  input  logic               rsp_stall_i,
  input  logic signed [31:0] rsp_data_i,
  input  logic [1:0]         rsp_status_i,
  input  logic signed [31:0] rsp_largest_i,
  input  logic signed [31:0] rsp_smallest_i,
  input  logic signed [39:0] rsp_mean_q8_i,
  input  logic [7:0]         rsp_count_i,
  output int                 pending_o,
  output int                 error_cnt_o
);

  localparam int DATA_W  = lss_pkg::DATA_W;
  localparam int MEAN_W  = lss_pkg::MEAN_W;
  localparam int COUNT_W = lss_pkg::COUNT_W;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] largest;
    logic signed [DATA_W-1:0] smallest;
    logic signed [MEAN_W-1:0] mean_q8;
    logic [COUNT_W-1:0]       count;
  } stack_result_t;

  // words held by the stack, bottom first
  logic signed [DATA_W-1:0] held_words[$];
  // results still owed by the block, oldest first
  stack_result_t            owed_results[$];
  int                       error_cnt = 0;

  assign error_cnt_o = error_cnt;

  // apply one request to the held words and work out its result
  function automatic stack_result_t stack_response(lss_pkg::mode_e mode,
                                                   logic signed [DATA_W-1:0] word);
    stack_result_t r;
    longint        sum;
    longint        quot;
    r.data     = '0;
    r.status   = lss_pkg::ST_OK;
    r.largest  = '0;
    r.smallest = '0;
    r.mean_q8  = '0;
    case (mode)
      lss_pkg::MODE_PUSH: begin
        if (held_words.size() >= DEPTH) r.status = lss_pkg::ST_FULL;
        else held_words.push_back(word);
      end
      lss_pkg::MODE_POP: begin
        if (held_words.size() == 0) r.status = lss_pkg::ST_EMPTY;
        else r.data = held_words.pop_back();
      end
      lss_pkg::MODE_PEEK: begin
        if (held_words.size() == 0) r.status = lss_pkg::ST_EMPTY;
        else r.data = held_words[$];
      end
      default: begin
        if (held_words.size() == 0) begin
          r.status = lss_pkg::ST_EMPTY;
        end else begin
          // scan with a wide sum, mean truncated toward zero
          sum        = 0;
          r.largest  = held_words[$];
          r.smallest = held_words[$];
          foreach (held_words[i]) begin
            sum += held_words[i];
            if (held_words[i] > r.largest) r.largest = held_words[i];
            if (held_words[i] < r.smallest) r.smallest = held_words[i];
          end
          quot      = (sum * 256) / longint'(held_words.size());
          r.mean_q8 = quot[MEAN_W-1:0];
        end
      end
    endcase
    r.count = COUNT_W'(held_words.size());
    return r;
  endfunction

  // compare one taken result with the oldest owed one
  task automatic check_result(stack_result_t got);
    stack_result_t want;
    if (owed_results.size() == 0) begin
      error_cnt++;
      if (error_cnt <= 10)
        $display("[%0t] result with nothing owed: data %0d status %0d count %0d",
                 $time, got.data, got.status, got.count);
    end else begin
      want = owed_results.pop_front();
      if (got.data !== want.data || got.status !== want.status ||
          got.largest !== want.largest || got.smallest !== want.smallest ||
          got.mean_q8 !== want.mean_q8 || got.count !== want.count) begin
        error_cnt++;
        if (error_cnt <= 10) begin
          $display({"[%0t] mismatch  expected: data %0d status %0d max %0d",
                    " min %0d mean %0d cnt %0d"},
                   $time, want.data, want.status, want.largest, want.smallest,
                   want.mean_q8, want.count);
          $display({"[%0t] mismatch  actual:   data %0d status %0d max %0d",
                    " min %0d mean %0d cnt %0d"},
                   $time, got.data, got.status, got.largest, got.smallest,
                   got.mean_q8, got.count);
        end
      end
    end
  endtask

  // watch both channels on every rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t got;
    if (!rst_ni) begin
      held_words.delete();
      owed_results.delete();
      pending_o <= 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        got.data     = rsp_data_i;
        got.status   = rsp_status_i;
        got.largest  = rsp_largest_i;
        got.smallest = rsp_smallest_i;
        got.mean_q8  = rsp_mean_q8_i;
        got.count    = rsp_count_i;
        check_result(got);
      end
      if (req_valid_i && !req_stall_i)
        owed_results.push_back(stack_response(lss_pkg::mode_e'(req_mode_i),
                                              req_value_i));
      pending_o <= owed_results.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: request stimulus, back-pressure and verdict for the statistics stack
module tb_top;

  localparam int DEPTH        = 128;
  localparam int PHASE_ITEMS  = 280;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 120;

  typedef enum int {
    BIAS_GROW,
    BIAS_SHRINK,
    BIAS_MIXED
  } bias_e;

  typedef enum int {
    WORDS_RANDOM,
    WORDS_MAX,
    WORDS_MIN
  } words_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         req_mode  = lss_pkg::MODE_PUSH;
  logic signed [31:0] req_value = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [31:0] rsp_data;
  logic [1:0]         rsp_status;
  logic signed [31:0] rsp_largest;
  logic signed [31:0] rsp_smallest;
  logic signed [39:0] rsp_mean_q8;
  logic [7:0]         rsp_count;

  int pending;
  int error_cnt;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int depth_seen = 0;
  int sent       = 0;
  int cycle_cnt  = 0;

  lifo_stack_with_statistics #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .mode_i     (req_mode),
    .value_i    (req_value),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .data_o     (rsp_data),
    .status_o   (rsp_status),
    .largest_o  (rsp_largest),
    .smallest_o (rsp_smallest),
    .mean_q8_o  (rsp_mean_q8),
    .count_o    (rsp_count)
  );

  lss_result_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (req_valid),
    .req_stall_i   (req_stall),
    .req_mode_i    (req_mode),
    .req_value_i   (req_value),
    .rsp_valid_i   (rsp_valid),
    .rsp_stall_i   (rsp_stall),
    .rsp_data_i    (rsp_data),
    .rsp_status_i  (rsp_status),
    .rsp_largest_i (rsp_largest),
    .rsp_smallest_i(rsp_smallest),
    .rsp_mean_q8_i (rsp_mean_q8),
    .rsp_count_i   (rsp_count),
    .pending_o     (pending),
    .error_cnt_o   (error_cnt)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // request mode drawn according to the wanted drift of the fill level
  function automatic lss_pkg::mode_e pick_mode(bias_e bias);
    int unsigned roll;
    roll = $urandom_range(99);
    case (bias)
      BIAS_GROW: begin
        if (roll < 85) return lss_pkg::MODE_PUSH;
        if (roll < 90) return lss_pkg::MODE_POP;
        if (roll < 95) return lss_pkg::MODE_PEEK;
        return lss_pkg::MODE_STATS;
      end
      BIAS_SHRINK: begin
        if (roll < 85) return lss_pkg::MODE_POP;
        if (roll < 90) return lss_pkg::MODE_PUSH;
        if (roll < 95) return lss_pkg::MODE_PEEK;
        return lss_pkg::MODE_STATS;
      end
      default: begin
        if (roll < 40) return lss_pkg::MODE_PUSH;
        if (roll < 70) return lss_pkg::MODE_POP;
        if (roll < 90) return lss_pkg::MODE_PEEK;
        return lss_pkg::MODE_STATS;
      end
    endcase
  endfunction

  // word to push: extremes, small signed values or anything
  function automatic logic [31:0] pick_word(words_e kind);
    case (kind)
      WORDS_MAX: return 32'h7FFF_FFFF;
      WORDS_MIN: return 32'h8000_0000;
      default: begin
        case ($urandom_range(7))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2, 3:    return 32'($urandom_range(200)) - 32'd100;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // one request, with optional idle cycles in front; returns at its acceptance edge
  task automatic send_request(input lss_pkg::mode_e mode, input logic [31:0] word);
    logic stalled;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_mode  <= mode;
    req_value <= word;
    do begin
      @(negedge clk);
      stalled = req_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
    if (mode == lss_pkg::MODE_PUSH && depth_seen < DEPTH) depth_seen++;
    if (mode == lss_pkg::MODE_POP && depth_seen > 0) depth_seen--;
  endtask

  // hold off until every owed result has been taken
  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int    phase_end;
    int    chunk_len;
    bias_e bias;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, extremes, truncation of negative means
    send_request(lss_pkg::MODE_STATS, $urandom());
    send_request(lss_pkg::MODE_POP, $urandom());
    send_request(lss_pkg::MODE_PEEK, $urandom());
    send_request(lss_pkg::MODE_PUSH, 32'h7FFF_FFFF);
    send_request(lss_pkg::MODE_PEEK, $urandom());
    send_request(lss_pkg::MODE_STATS, $urandom());
    send_request(lss_pkg::MODE_PUSH, 32'h8000_0000);
    send_request(lss_pkg::MODE_STATS, $urandom());
    send_request(lss_pkg::MODE_PUSH, 32'hFFFF_FFFF);
    send_request(lss_pkg::MODE_STATS, $urandom());
    send_request(lss_pkg::MODE_PUSH, 32'd1);
    send_request(lss_pkg::MODE_PUSH, 32'd0);
    send_request(lss_pkg::MODE_PEEK, $urandom());
    send_request(lss_pkg::MODE_STATS, $urandom());
    repeat (5) send_request(lss_pkg::MODE_POP, $urandom());
    send_request(lss_pkg::MODE_POP, $urandom());
    send_request(lss_pkg::MODE_STATS, $urandom());
    send_request(lss_pkg::MODE_PEEK, $urandom());
    send_request(lss_pkg::MODE_PUSH, 32'hDEAD_BEEF);
    send_request(lss_pkg::MODE_POP, $urandom());
    wait_for_results();

    // random phases, each filling to full and draining past empty
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 73; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      phase_end = sent + PHASE_ITEMS;

      // fill up, then overrun with pushes when full
      while (depth_seen < DEPTH)
        send_request(pick_mode(BIAS_GROW), pick_word(words_e'(phase % 3)));
      repeat (3) send_request(lss_pkg::MODE_PUSH, pick_word(WORDS_RANDOM));
      send_request(lss_pkg::MODE_STATS, $urandom());

      // wandering chunks
      while (sent < phase_end) begin
        bias      = bias_e'($urandom_range(2));
        chunk_len = $urandom_range(10, 60);
        repeat (chunk_len) send_request(pick_mode(bias), pick_word(WORDS_RANDOM));
      end

      // drain, then underrun
      while (depth_seen > 0)
        send_request(pick_mode(BIAS_SHRINK), pick_word(WORDS_RANDOM));
      repeat (2) send_request(lss_pkg::MODE_POP, $urandom());
      send_request(lss_pkg::MODE_PEEK, $urandom());
      send_request(lss_pkg::MODE_STATS, $urandom());
      wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
